>>> rtl/sraru_pkg.sv
// Shared constants, types and helpers for the SHiP/RRIP stream-aware replacement unit.
package sraru_pkg;

    localparam int NUM_SETS       = 2048;
    localparam int NUM_WAYS       = 16;
    localparam int SIG_TABLE_SIZE = 8192;

    localparam int SET_W    = 11;
    localparam int WAY_W    = 4;
    localparam int MASK_W   = 16;
    localparam int SIG_W    = 13;
    localparam int RRPV_W   = 2;
    localparam int CTR_W    = 2;
    localparam int ADDR_W   = 64;
    localparam int ROW_W    = NUM_WAYS * RRPV_W;
    localparam int STREAM_W = CTR_W + ADDR_W;

    localparam logic [RRPV_W-1:0] RRPV_MAX    = 2'd3;
    localparam logic [RRPV_W-1:0] RRPV_NEAR   = 2'd0;
    localparam logic [RRPV_W-1:0] RRPV_LONG   = 2'd2;
    localparam logic [CTR_W-1:0]  CTR_MAX     = 2'd3;
    localparam logic [CTR_W-1:0]  CTR_RESET   = 2'd1;
    localparam logic [ADDR_W-1:0] STRIDE      = 64'd64;

    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_CALC  = 4'b1000
    } state_t;

    function automatic logic [SIG_W-1:0] sig_of(input logic [ADDR_W-1:0] pc);
        return pc[SIG_W-1:0] ^ pc[SIG_W+3:4];
    endfunction

endpackage

>>> rtl/ship_rrip_stream_aware_replacement_unit.sv
// Top level of the SHiP/RRIP stream-aware replacement unit.
// After reset the unit sweeps its tables (busy high) to load reset values.
// Each request then steps through accept, memory read, and compute with write-back;
// busy is high for the read and compute steps. A victim request answers with done
// high for one cycle in the same cycle that busy falls; the receiver cannot stall it.
// An update request gives no answer.
module ship_rrip_stream_aware_replacement_unit
    import sraru_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              op,
    input  logic [SET_W-1:0]  set_index,
    input  logic [WAY_W-1:0]  way_index,
    input  logic [MASK_W-1:0] valid_mask,
    input  logic [ADDR_W-1:0] pc,
    input  logic [ADDR_W-1:0] phys_addr,
    input  logic              was_hit,
    output logic              done,
    output logic [WAY_W-1:0]  victim_way
);

    state_t state_reg, state_next;
    logic [SIG_W-1:0] clr_reg, clr_next;
    logic done_reg, done_next;
    logic [WAY_W-1:0] victim_reg, victim_next;

    logic              op_reg;
    logic [SET_W-1:0]  set_reg;
    logic [WAY_W-1:0]  way_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [SIG_W-1:0]  sig_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              hit_reg;

    logic                rrpv_we, ctr_we, str_we;
    logic [SET_W-1:0]    rrpv_waddr, str_waddr;
    logic [SIG_W-1:0]    ctr_waddr;
    logic [ROW_W-1:0]    rrpv_wdata, rrpv_rdata;
    logic [CTR_W-1:0]    ctr_wdata, ctr_rdata;
    logic [STREAM_W-1:0] str_wdata, str_rdata;

    logic [ROW_W-1:0]    row_new;
    logic [RRPV_W-1:0]   top;
    logic [WAY_W-1:0]    first_free, first_top;
    logic                all_valid;
    logic [ADDR_W-1:0]   prev, delta;
    logic [CTR_W-1:0]    cnt, cnt_new, ctr_new;
    logic [RRPV_W-1:0]   ins_rrpv, age_add;

    sraru_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_rrpv_ram (
        .clk(clk), .we(rrpv_we), .waddr(rrpv_waddr), .wdata(rrpv_wdata),
        .raddr(set_reg), .rdata(rrpv_rdata)
    );

    sraru_ram #(.WIDTH(CTR_W), .DEPTH(SIG_TABLE_SIZE)) u_ctr_ram (
        .clk(clk), .we(ctr_we), .waddr(ctr_waddr), .wdata(ctr_wdata),
        .raddr(sig_reg), .rdata(ctr_rdata)
    );

    sraru_ram #(.WIDTH(STREAM_W), .DEPTH(NUM_SETS)) u_stream_ram (
        .clk(clk), .we(str_we), .waddr(str_waddr), .wdata(str_wdata),
        .raddr(set_reg), .rdata(str_rdata)
    );

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign victim_way = victim_reg;

    // victim search
    always_comb
    begin
        all_valid  = &mask_reg;
        first_free = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--)
        begin
            if (!mask_reg[i])
            begin
                first_free = WAY_W'(i);
            end
        end
        top = '0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (rrpv_rdata[i*RRPV_W +: RRPV_W] > top)
            begin
                top = rrpv_rdata[i*RRPV_W +: RRPV_W];
            end
        end
        first_top = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--)
        begin
            if (rrpv_rdata[i*RRPV_W +: RRPV_W] == top)
            begin
                first_top = WAY_W'(i);
            end
        end
        age_add = RRPV_MAX - top;
    end

    // update path and victim row aging
    always_comb
    begin
        prev    = str_rdata[ADDR_W-1:0];
        cnt     = str_rdata[STREAM_W-1:ADDR_W];
        delta   = (prev != '0) ? (addr_reg - prev) : '0;
        cnt_new = cnt;
        if (delta == STRIDE || delta == (~STRIDE + 64'd1))
        begin
            if (cnt != CTR_MAX)
            begin
                cnt_new = cnt + 2'd1;
            end
        end
        else if (cnt != '0)
        begin
            cnt_new = cnt - 2'd1;
        end

        ctr_new = ctr_rdata;
        if (hit_reg)
        begin
            ins_rrpv = RRPV_NEAR;
            if (ctr_rdata != CTR_MAX)
            begin
                ctr_new = ctr_rdata + 2'd1;
            end
        end
        else if (cnt_new == CTR_MAX)
        begin
            ins_rrpv = RRPV_MAX;
            if (ctr_rdata != '0)
            begin
                ctr_new = ctr_rdata - 2'd1;
            end
        end
        else if (ctr_rdata > 2'd1)
        begin
            ins_rrpv = RRPV_NEAR;
        end
        else
        begin
            ins_rrpv = RRPV_LONG;
        end

        row_new = rrpv_rdata;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (op_reg == OP_VICTIM)
            begin
                row_new[i*RRPV_W +: RRPV_W] = rrpv_rdata[i*RRPV_W +: RRPV_W] + age_add;
            end
            else if (way_reg == WAY_W'(i))
            begin
                row_new[i*RRPV_W +: RRPV_W] = ins_rrpv;
            end
        end
    end

    // sequencer and memory write control
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        victim_next = victim_reg;
        rrpv_we     = 1'b0;
        ctr_we      = 1'b0;
        str_we      = 1'b0;
        rrpv_waddr  = set_reg;
        str_waddr   = set_reg;
        ctr_waddr   = sig_reg;
        rrpv_wdata  = row_new;
        ctr_wdata   = ctr_new;
        str_wdata   = {cnt_new, addr_reg};
        unique case (state_reg)
            S_CLEAR:
            begin
                rrpv_we    = 1'b1;
                ctr_we     = 1'b1;
                str_we     = 1'b1;
                rrpv_waddr = clr_reg[SET_W-1:0];
                str_waddr  = clr_reg[SET_W-1:0];
                ctr_waddr  = clr_reg;
                rrpv_wdata = '1;
                ctr_wdata  = CTR_RESET;
                str_wdata  = '0;
                clr_next   = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                state_next = S_IDLE;
                if (op_reg == OP_VICTIM)
                begin
                    done_next   = 1'b1;
                    victim_next = all_valid ? first_top : first_free;
                    rrpv_we     = all_valid;
                end
                else
                begin
                    rrpv_we = 1'b1;
                    ctr_we  = 1'b1;
                    str_we  = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    // hold request fields and victim result
    always_ff @(posedge clk)
    begin
        victim_reg <= victim_next;
        if (state_reg == S_IDLE && start)
        begin
            op_reg   <= op;
            set_reg  <= set_index;
            way_reg  <= way_index;
            mask_reg <= valid_mask;
            sig_reg  <= sig_of(pc);
            addr_reg <= phys_addr;
            hit_reg  <= was_hit;
        end
    end

    a_done_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_CALC))
        else $error("done without a compute cycle");

    a_done_victim_only: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (op_reg == OP_VICTIM))
        else $error("done raised for an update request");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but unit not busy");

endmodule

>>> rtl/sraru_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sraru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
